@@ hdl/salcp_pkg.sv @@
// Shared constants and types of the suffix array and LCP builder.
`timescale 1ns / 1ps
package salcp_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int ALPHABET = 256;
  localparam int SYM_W    = 8;
  localparam int AW       = $clog2(MAX_TEXT + 1);
  localparam int DEPTH    = MAX_TEXT + 1;
  localparam int CW       = AW + 1;
  localparam int LCP_W    = 12;
  localparam int RANK_W   = 13;
  localparam int ST_W     = 33;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // which count table a prefix sweep runs over, and what follows it
  typedef enum logic [2:0] {
    PF_SYM    = 3'b001,
    PF_SECOND = 3'b010,
    PF_FIRST  = 3'b100
  } pf_sel_t;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    logic [RANK_W-1:0] rank_index;
  } cmd_t;

  typedef struct packed {
    logic [AW-1:0]    suffix_start;
    logic [LCP_W-1:0] lcp_length;
    logic             error_flag;
  } res_t;

  typedef enum logic [ST_W-1:0] {
    S_IDLE = 33'd1 << 0,
    S_CLR  = 33'd1 << 1,
    S_H1A  = 33'd1 << 2,
    S_H1B  = 33'd1 << 3,
    S_H1C  = 33'd1 << 4,
    S_PFA  = 33'd1 << 5,
    S_PFB  = 33'd1 << 6,
    S_SC1A = 33'd1 << 7,
    S_SC1B = 33'd1 << 8,
    S_SC1C = 33'd1 << 9,
    S_RK0A = 33'd1 << 10,
    S_RK0B = 33'd1 << 11,
    S_RK0C = 33'd1 << 12,
    S_KYA  = 33'd1 << 13,
    S_KYB  = 33'd1 << 14,
    S_KYC  = 33'd1 << 15,
    S_KYD  = 33'd1 << 16,
    S_SC2A = 33'd1 << 17,
    S_SC2B = 33'd1 << 18,
    S_SC2C = 33'd1 << 19,
    S_SC3A = 33'd1 << 20,
    S_SC3B = 33'd1 << 21,
    S_SC3C = 33'd1 << 22,
    S_SC3D = 33'd1 << 23,
    S_RRA  = 33'd1 << 24,
    S_RRB  = 33'd1 << 25,
    S_RRC  = 33'd1 << 26,
    S_LCA  = 33'd1 << 27,
    S_LCB  = 33'd1 << 28,
    S_LCK  = 33'd1 << 29,
    S_LCC  = 33'd1 << 30,
    S_LCD  = 33'd1 << 31,
    S_RD   = 33'd1 << 32
  } state_t;

endpackage

@@ hdl/suffix_array_lcp_builder_core.sv @@
// Top level: stream ports, result word register and the build engine.
`timescale 1ns / 1ps
// Loads a text one symbol word per cycle while s_tready is high (tuser 0),
// and the word with tlast set starts a build of the suffix array and the LCP
// table; a read word (tuser 1) returns start position and LCP length at a
// rank through the read state and the output word register. During a build
// s_tready stays low. All tables sit in single-port memories (the text
// memory has a second read port for the LCP compare), so each loop step costs
// one memory access per cycle; a text of n symbols takes a symbol sort, up to
// about log2 n doubling passes and the LCP walk.
module suffix_array_lcp_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // symbol [7:0], rank_index [20:8], zero fill
  input  logic        s_tuser,  // op
  input  logic        s_tlast,  // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // suffix_start [12:0], lcp_length [24:13], zero fill
  output logic        m_tuser   // error_flag
);
  import salcp_pkg::*;

  cmd_t cmd;
  res_t res, out_res;
  logic eng_idle, res_valid, res_ready, cmd_valid;

  assign cmd.op         = op_t'(s_tuser);
  assign cmd.symbol     = s_tdata[SYM_W-1:0];
  assign cmd.last       = s_tlast;
  assign cmd.rank_index = s_tdata[SYM_W +: RANK_W];

  assign s_tready  = eng_idle;
  assign cmd_valid = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  salcp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .idle      (eng_idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res <= res;
  end

  assign m_tdata = {7'b0, out_res.lcp_length, out_res.suffix_start};
  assign m_tuser = out_res.error_flag;

endmodule

@@ hdl/salcp_engine.sv @@
// Text store, sort tables and the sequencer that builds suffix order and LCP.
`timescale 1ns / 1ps
module salcp_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  salcp_pkg::cmd_t cmd,
  output logic            idle,
  input  logic            res_ready,
  output logic            res_valid,
  output salcp_pkg::res_t res
);
  import salcp_pkg::*;

  // memories
  logic [SYM_W-1:0] tx_mem  [DEPTH];
  logic [AW-1:0]    sa_mem  [DEPTH];
  logic [AW-1:0]    rk_mem  [DEPTH];
  logic [AW-1:0]    c1_mem  [DEPTH];
  logic [AW-1:0]    c2_mem  [DEPTH];
  logic [AW-1:0]    ky1_mem [DEPTH];
  logic [AW-1:0]    ky2_mem [DEPTH];
  logic [AW-1:0]    tp_mem  [DEPTH];
  logic [LCP_W-1:0] lcp_mem [DEPTH];

  logic             tx_we, sa_we, rk_we, c1_we, c2_we, ky_we, tp_we, lcp_we;
  logic [AW-1:0]    tx_wa, sa_wa, rk_wa, c1_wa, c2_wa, ky_wa, tp_wa, lcp_wa;
  logic [SYM_W-1:0] tx_wd;
  logic [AW-1:0]    sa_wd, rk_wd, c1_wd, c2_wd, ky1_wd, ky2_wd, tp_wd;
  logic [LCP_W-1:0] lcp_wd;
  logic [AW-1:0]    tx_ra, tx_ra2, sa_ra, rk_ra, c1_ra, c2_ra, ky_ra, tp_ra, lcp_ra;
  logic [SYM_W-1:0] tx_rd, tx_rd2;
  logic [AW-1:0]    sa_rd, rk_rd, c1_rd, c2_rd, ky1_rd, ky2_rd, tp_rd;
  logic [LCP_W-1:0] lcp_rd;

  // control registers
  state_t        state;
  pf_sel_t       pf_sel;
  logic          built, ovf, pass_mode, k2_ok, rd_err;
  logic [AW-1:0] n, i, j, lim, acc, r, cur_key, cur_key2, cur_idx, h;
  logic [AW-1:0] p1, p2;
  logic [SYM_W-1:0] prev_sym;
  logic [CW-1:0] l;

  // derived values
  logic [AW-1:0] len_base, r_new, k2_val;
  logic          room, bound, diff_pair;
  logic [CW-1:0] ih, kh, il, n_ext;

  assign len_base  = built ? '0 : n;
  assign room      = len_base < AW'(MAX_TEXT);
  assign n_ext     = {1'b0, n};
  assign ih        = {1'b0, i} + {1'b0, h};
  assign kh        = {1'b0, cur_key} + {1'b0, h};
  assign il        = {1'b0, i} + l;
  assign bound     = (ih <= n_ext) && (kh <= n_ext);
  assign k2_val    = k2_ok ? rk_rd : '0;
  assign diff_pair = (ky1_rd != p1) || (ky2_rd != p2);

  always_comb begin
    r_new = r;
    if (i == AW'(1)) begin
      r_new = AW'(1);
    end else if (state == S_RK0C) begin
      r_new = r + AW'(tx_rd != prev_sym);
    end else begin
      r_new = r + AW'(diff_pair);
    end
  end

  assign idle = (state == S_IDLE);

  // memory arrays, registered reads
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    tx_rd  <= tx_mem[tx_ra];
    tx_rd2 <= tx_mem[tx_ra2];
  end
  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_rd <= sa_mem[sa_ra];
  end
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    rk_rd <= rk_mem[rk_ra];
  end
  always_ff @(posedge clk) begin
    if (c1_we) c1_mem[c1_wa] <= c1_wd;
    c1_rd <= c1_mem[c1_ra];
  end
  always_ff @(posedge clk) begin
    if (c2_we) c2_mem[c2_wa] <= c2_wd;
    c2_rd <= c2_mem[c2_ra];
  end
  always_ff @(posedge clk) begin
    if (ky_we) ky1_mem[ky_wa] <= ky1_wd;
    ky1_rd <= ky1_mem[ky_ra];
  end
  always_ff @(posedge clk) begin
    if (ky_we) ky2_mem[ky_wa] <= ky2_wd;
    ky2_rd <= ky2_mem[ky_ra];
  end
  always_ff @(posedge clk) begin
    if (tp_we) tp_mem[tp_wa] <= tp_wd;
    tp_rd <= tp_mem[tp_ra];
  end
  always_ff @(posedge clk) begin
    if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
    lcp_rd <= lcp_mem[lcp_ra];
  end

  // memory port steering per sequencer step
  always_comb begin
    tx_we = 1'b0; sa_we = 1'b0; rk_we = 1'b0; c1_we = 1'b0; c2_we = 1'b0;
    ky_we = 1'b0; tp_we = 1'b0; lcp_we = 1'b0;
    tx_wa = '0; sa_wa = '0; rk_wa = '0; c1_wa = '0; c2_wa = '0;
    ky_wa = '0; tp_wa = '0; lcp_wa = '0;
    tx_wd = '0; sa_wd = '0; rk_wd = '0; c1_wd = '0; c2_wd = '0;
    ky1_wd = '0; ky2_wd = '0; tp_wd = '0; lcp_wd = '0;
    tx_ra = '0; tx_ra2 = '0; sa_ra = '0; rk_ra = '0; c1_ra = '0; c2_ra = '0;
    ky_ra = '0; tp_ra = '0; lcp_ra = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.op == OP_APPEND && room) begin
          tx_we = 1'b1;
          tx_wa = len_base + AW'(1);
          tx_wd = cmd.symbol;
        end
        sa_ra  = cmd.rank_index;
        lcp_ra = cmd.rank_index;
      end
      S_CLR: begin
        c1_we = 1'b1; c1_wa = j;
        c2_we = 1'b1; c2_wa = j;
      end
      S_H1A: tx_ra = i;
      S_H1B: c1_ra = AW'(tx_rd);
      S_H1C: begin
        c1_we = 1'b1; c1_wa = cur_key; c1_wd = c1_rd + AW'(1);
      end
      S_PFA: begin
        c1_ra = j; c2_ra = j;
      end
      S_PFB: begin
        if (pf_sel == PF_SECOND) begin
          c2_we = 1'b1; c2_wa = j; c2_wd = acc + c2_rd;
        end else begin
          c1_we = 1'b1; c1_wa = j; c1_wd = acc + c1_rd;
        end
      end
      S_SC1A: tx_ra = i;
      S_SC1B: c1_ra = AW'(tx_rd);
      S_SC1C: begin
        sa_we = 1'b1; sa_wa = c1_rd;   sa_wd = i;
        c1_we = 1'b1; c1_wa = cur_key; c1_wd = c1_rd - AW'(1);
      end
      S_RK0A: sa_ra = i;
      S_RK0B: tx_ra = sa_rd;
      S_RK0C: begin
        rk_we = 1'b1; rk_wa = cur_idx; rk_wd = r_new;
      end
      S_KYA: rk_ra = i;
      S_KYB: rk_ra = il[AW-1:0];
      S_KYC: begin
        ky_we = 1'b1; ky_wa = i; ky1_wd = cur_key; ky2_wd = k2_val;
        c1_ra = cur_key; c2_ra = k2_val;
      end
      S_KYD: begin
        c1_we = 1'b1; c1_wa = cur_key;  c1_wd = c1_rd + AW'(1);
        c2_we = 1'b1; c2_wa = cur_key2; c2_wd = c2_rd + AW'(1);
      end
      S_SC2A: ky_ra = i;
      S_SC2B: c2_ra = ky2_rd;
      S_SC2C: begin
        tp_we = 1'b1; tp_wa = c2_rd;   tp_wd = i;
        c2_we = 1'b1; c2_wa = cur_key; c2_wd = c2_rd - AW'(1);
      end
      S_SC3A: tp_ra = i;
      S_SC3B: ky_ra = tp_rd;
      S_SC3C: c1_ra = ky1_rd;
      S_SC3D: begin
        sa_we = 1'b1; sa_wa = c1_rd;   sa_wd = cur_idx;
        c1_we = 1'b1; c1_wa = cur_key; c1_wd = c1_rd - AW'(1);
      end
      S_RRA: sa_ra = i;
      S_RRB: ky_ra = sa_rd;
      S_RRC: begin
        rk_we = 1'b1; rk_wa = cur_idx; rk_wd = r_new;
      end
      S_LCA: rk_ra = i;
      S_LCB: begin
        sa_ra = rk_rd - AW'(1);
        if (rk_rd <= AW'(1)) begin
          lcp_we = 1'b1; lcp_wa = AW'(1);
        end
      end
      S_LCK: ;
      S_LCC: begin
        tx_ra  = ih[AW-1:0];
        tx_ra2 = kh[AW-1:0];
        if (!bound) begin
          lcp_we = 1'b1; lcp_wa = r; lcp_wd = h[LCP_W-1:0];
        end
      end
      S_LCD: begin
        if (tx_rd != tx_rd2) begin
          lcp_we = 1'b1; lcp_wa = r; lcp_wd = h[LCP_W-1:0];
        end
      end
      S_RD: begin
        sa_ra  = cur_key;
        lcp_ra = cur_key;
      end
      default: ;
    endcase
  end

  // read result
  assign res_valid        = (state == S_RD) && res_ready;
  assign res.suffix_start = rd_err ? '0 : sa_rd;
  assign res.lcp_length   = rd_err ? '0 : lcp_rd;
  assign res.error_flag   = rd_err || ovf;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      built     <= 1'b0;
      ovf       <= 1'b0;
      n         <= '0;
      pass_mode <= 1'b0;
      pf_sel    <= PF_SYM;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.op == OP_APPEND) begin
            built <= 1'b0;
            if (room) begin
              n   <= len_base + AW'(1);
              ovf <= built ? 1'b0 : ovf;
            end else begin
              n   <= len_base;
              ovf <= 1'b1;
            end
            if (cmd.last) begin
              pass_mode <= 1'b0;
              lim       <= AW'(ALPHABET - 1);
              j         <= '0;
              state     <= S_CLR;
            end
          end else if (cmd_valid) begin
            cur_key <= cmd.rank_index;
            rd_err  <= !built || cmd.rank_index == '0 || cmd.rank_index > n;
            state   <= S_RD;
          end
        end
        S_CLR: begin
          if (j == lim) begin
            i     <= AW'(1);
            state <= pass_mode ? S_KYA : S_H1A;
          end else begin
            j <= j + AW'(1);
          end
        end
        // symbol histogram
        S_H1A: state <= S_H1B;
        S_H1B: begin
          cur_key <= AW'(tx_rd);
          state   <= S_H1C;
        end
        S_H1C: begin
          if (i == n) begin
            j      <= '0;
            acc    <= '0;
            pf_sel <= PF_SYM;
            state  <= S_PFA;
          end else begin
            i     <= i + AW'(1);
            state <= S_H1A;
          end
        end
        // running sum over a count table
        S_PFA: state <= S_PFB;
        S_PFB: begin
          acc <= acc + ((pf_sel == PF_SECOND) ? c2_rd : c1_rd);
          if (j == lim) begin
            i <= n;
            unique case (pf_sel)
              PF_SYM:    state <= S_SC1A;
              PF_SECOND: state <= S_SC2A;
              PF_FIRST:  state <= S_SC3A;
              default:   state <= S_SC1A;
            endcase
          end else begin
            j     <= j + AW'(1);
            state <= S_PFA;
          end
        end
        // scatter by symbol
        S_SC1A: state <= S_SC1B;
        S_SC1B: begin
          cur_key <= AW'(tx_rd);
          state   <= S_SC1C;
        end
        S_SC1C: begin
          if (i == AW'(1)) begin
            state <= S_RK0A;
          end else begin
            i     <= i - AW'(1);
            state <= S_SC1A;
          end
        end
        // initial ranks
        S_RK0A: state <= S_RK0B;
        S_RK0B: begin
          cur_idx <= sa_rd;
          state   <= S_RK0C;
        end
        S_RK0C: begin
          r        <= r_new;
          prev_sym <= tx_rd;
          if (i == n) begin
            l <= CW'(1);
            if (r_new < n) begin
              pass_mode <= 1'b1;
              lim       <= n;
              j         <= '0;
              state     <= S_CLR;
            end else begin
              i     <= AW'(1);
              h     <= '0;
              state <= S_LCA;
            end
          end else begin
            i     <= i + AW'(1);
            state <= S_RK0A;
          end
        end
        // key pairs and their histograms
        S_KYA: state <= S_KYB;
        S_KYB: begin
          cur_key <= rk_rd;
          k2_ok   <= il <= n_ext;
          state   <= S_KYC;
        end
        S_KYC: begin
          cur_key2 <= k2_val;
          state    <= S_KYD;
        end
        S_KYD: begin
          if (i == n) begin
            j      <= '0;
            acc    <= '0;
            pf_sel <= PF_SECOND;
            state  <= S_PFA;
          end else begin
            i     <= i + AW'(1);
            state <= S_KYA;
          end
        end
        // scatter by second key
        S_SC2A: state <= S_SC2B;
        S_SC2B: begin
          cur_key <= ky2_rd;
          state   <= S_SC2C;
        end
        S_SC2C: begin
          if (i == AW'(1)) begin
            j      <= '0;
            acc    <= '0;
            pf_sel <= PF_FIRST;
            state  <= S_PFA;
          end else begin
            i     <= i - AW'(1);
            state <= S_SC2A;
          end
        end
        // stable scatter by first key
        S_SC3A: state <= S_SC3B;
        S_SC3B: begin
          cur_idx <= tp_rd;
          state   <= S_SC3C;
        end
        S_SC3C: begin
          cur_key <= ky1_rd;
          state   <= S_SC3D;
        end
        S_SC3D: begin
          if (i == AW'(1)) begin
            state <= S_RRA;
          end else begin
            i     <= i - AW'(1);
            state <= S_SC3A;
          end
        end
        // re-rank from key pairs
        S_RRA: state <= S_RRB;
        S_RRB: begin
          cur_idx <= sa_rd;
          state   <= S_RRC;
        end
        S_RRC: begin
          r  <= r_new;
          p1 <= ky1_rd;
          p2 <= ky2_rd;
          if (i == n) begin
            l <= l << 1;
            if (r_new < n) begin
              j     <= '0;
              state <= S_CLR;
            end else begin
              i     <= AW'(1);
              h     <= '0;
              state <= S_LCA;
            end
          end else begin
            i     <= i + AW'(1);
            state <= S_RRA;
          end
        end
        // Kasai walk
        S_LCA: begin
          if (h != '0) h <= h - AW'(1);
          state <= S_LCB;
        end
        S_LCB: begin
          r <= rk_rd;
          if (rk_rd <= AW'(1)) begin
            h <= '0;
            if (i == n) begin
              built <= 1'b1;
              state <= S_IDLE;
            end else begin
              i     <= i + AW'(1);
              state <= S_LCA;
            end
          end else begin
            state <= S_LCK;
          end
        end
        S_LCK: begin
          cur_key <= sa_rd;
          state   <= S_LCC;
        end
        S_LCC: begin
          if (bound) begin
            state <= S_LCD;
          end else if (i == n) begin
            built <= 1'b1;
            state <= S_IDLE;
          end else begin
            i     <= i + AW'(1);
            state <= S_LCA;
          end
        end
        S_LCD: begin
          if (tx_rd == tx_rd2) begin
            h     <= h + AW'(1);
            state <= S_LCC;
          end else if (i == n) begin
            built <= 1'b1;
            state <= S_IDLE;
          end else begin
            i     <= i + AW'(1);
            state <= S_LCA;
          end
        end
        S_RD: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/salcp_checker.sv @@
// Port-level checks of the builder, bound to the top level.
`timescale 1ns / 1ps
module salcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed under stall");

  // an append never yields a word
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("word after append");

  // the final symbol starts a build, input is held off
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
    else $error("input taken during build start");

  // a read holds input off while its word is fetched
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken during read");

  // a clean result always points at a real suffix
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[12:0] != 13'd0)
    else $error("clean result with zero start");

endmodule

bind suffix_array_lcp_builder_core salcp_checker u_chk (.*);

@@ bench/tb.sv @@
// Self-checking bench for the suffix array and LCP builder core.
`timescale 1ns / 1ps
module tb;
  import salcp_pkg::*;

  localparam int TEXT_CAP = 4096;

  typedef struct {
    op_t        op;
    logic [7:0] sym;
    logic       last;
    logic [12:0] rank;
  } word_t;

  typedef struct {
    logic [12:0] start;
    logic [11:0] lcp;
    logic        err;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  word_t  pending[$];
  entry_t expected_entries[$];
  int     total_words;
  int     accepted_words = 0;
  int     reads_checked = 0;
  int     texts_built = 0;
  int     mismatches = 0;

  // predictor state
  logic [7:0] txt[1:TEXT_CAP];
  int         txt_len = 0;
  bit         txt_ovf = 1'b0;
  bit         txt_built = 1'b0;
  int         sfx_order[1:TEXT_CAP];
  int         lcp_tab[1:TEXT_CAP];

  always #6 clk = ~clk;

  suffix_array_lcp_builder_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // suffix a sorts below suffix b; the text end sorts below every symbol
  function automatic bit suffix_below(int a, int b);
    int k;
    for (k = 0; ; k++) begin
      if (a + k > txt_len) return 1'b1;
      if (b + k > txt_len) return 1'b0;
      if (txt[a+k] != txt[b+k]) return txt[a+k] < txt[b+k];
    end
  endfunction

  // sort suffixes by binary insertion, then direct LCP of neighbours
  task automatic build_suffix_table();
    int i, lo, hi, mid, j, h;
    for (i = 1; i <= txt_len; i++) begin
      lo = 1;
      hi = i;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (suffix_below(i, sfx_order[mid])) hi = mid;
        else lo = mid + 1;
      end
      for (j = i; j > lo; j--) sfx_order[j] = sfx_order[j-1];
      sfx_order[lo] = i;
    end
    if (txt_len > 0) lcp_tab[1] = 0;
    for (i = 2; i <= txt_len; i++) begin
      h = 0;
      while (sfx_order[i] + h <= txt_len && sfx_order[i-1] + h <= txt_len &&
             txt[sfx_order[i]+h] == txt[sfx_order[i-1]+h])
        h++;
      lcp_tab[i] = h;
    end
  endtask

  task automatic apply_word(word_t w);
    entry_t e;
    if (w.op == OP_APPEND) begin
      if (txt_built) begin
        txt_built = 1'b0;
        txt_len = 0;
        txt_ovf = 1'b0;
      end
      if (txt_len < TEXT_CAP) begin
        txt_len++;
        txt[txt_len] = w.sym;
      end else begin
        txt_ovf = 1'b1;
      end
      if (w.last) begin
        build_suffix_table();
        txt_built = 1'b1;
        texts_built++;
      end
    end else begin
      if (!txt_built || w.rank == 0 || w.rank > txt_len) begin
        e.start = '0;
        e.lcp = '0;
        e.err = 1'b1;
      end else begin
        e.start = 13'(sfx_order[w.rank]);
        e.lcp = 12'(lcp_tab[w.rank]);
        e.err = txt_ovf;
      end
      expected_entries.push_back(e);
    end
  endtask

  function automatic int phase_now();
    int p;
    p = accepted_words * 4 / (total_words + 1);
    return (p > 3) ? 3 : p;
  endfunction

  // sender: holds a word until taken, may idle between words
  always @(posedge clk) begin
    bit go;
    int p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_word(pending.pop_front());
        accepted_words++;
      end
      if (!s_tvalid || s_tready) begin
        p = phase_now();
        go = pending.size() > 0;
        if (p == 1 && $urandom_range(99) < 59) go = 1'b0;
        if (p == 3 && $urandom_range(99) < 30) go = 1'b0;
        s_tvalid <= go;
        if (go) begin
          s_tdata <= {3'b000, pending[0].rank, pending[0].sym};
          s_tuser <= pending[0].op;
          s_tlast <= pending[0].last;
        end
      end
    end
  end

  // receiver: random stalls, check each word against the oldest entry
  always @(posedge clk) begin
    entry_t e;
    int p;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        reads_checked++;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected result word %h err %b", m_tdata, m_tuser);
        end else begin
          e = expected_entries.pop_front();
          if (m_tdata[12:0] !== e.start || m_tdata[24:13] !== e.lcp || m_tuser !== e.err)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: mismatch exp start %0d lcp %0d err %b, got %0d %0d %b",
                       e.start, e.lcp, e.err, m_tdata[12:0], m_tdata[24:13], m_tuser);
          end
        end
      end
      p = phase_now();
      if (p == 2) m_tready <= $urandom_range(99) >= 59;
      else if (p == 3) m_tready <= $urandom_range(99) >= 30;
      else m_tready <= 1'b1;
    end
  end

  task automatic put(op_t op, int sym, bit last, int rank);
    word_t w;
    w.op = op;
    w.sym = 8'(sym);
    w.last = last;
    w.rank = 13'(rank);
    pending.push_back(w);
  endtask

  // text of n symbols; top 0 means any byte, else symbols 1..top
  task automatic put_text(int n, int top, bit noisy);
    int i;
    for (i = 0; i < n; i++) begin
      put(OP_APPEND, (top == 0) ? $urandom_range(255) : $urandom_range(top, 1),
          i == n - 1, 0);
      if (noisy && $urandom_range(99) < 8) put(OP_READ, 0, 1'b0, $urandom_range(n, 0));
    end
  endtask

  initial begin
    int n, k, r;
    // directed: read with no build, zero and top symbols, range edges
    put(OP_READ, 0, 1'b0, 1);
    put(OP_APPEND, 255, 1'b0, 0);
    put(OP_APPEND, 0, 1'b0, 0);
    put(OP_APPEND, 255, 1'b0, 0);
    put(OP_APPEND, 0, 1'b0, 0);
    put(OP_APPEND, 0, 1'b1, 0);
    for (r = 0; r <= 6; r++) put(OP_READ, 0, 1'b0, r);
    put(OP_READ, 8'hff, 1'b1, 8191);
    // repeated symbol forces every doubling pass
    put_text(4, 1, 1'b0);
    for (r = 1; r <= 4; r++) put(OP_READ, 0, 1'b0, r);
    // random texts, mostly short
    while (pending.size() < 1500) begin
      n = ($urandom_range(99) < 10) ? $urandom_range(200, 25) : $urandom_range(24, 1);
      case ($urandom_range(2))
        0: put_text(n, 2, 1'b1);
        1: put_text(n, 4, 1'b1);
        default: put_text(n, 0, 1'b1);
      endcase
      k = $urandom_range(8, 1);
      repeat (k) begin
        if ($urandom_range(99) < 85)
          put(OP_READ, 0, 1'($urandom_range(1)), $urandom_range(n, 1));
        else put(OP_READ, 0, 1'b0, $urandom_range(8191));
      end
    end
    total_words = pending.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || expected_entries.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("tb: %0d words sent, %0d texts built, %0d read results checked",
             accepted_words, texts_built, reads_checked);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 5000000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
